// ===== rtl/core/srtw_pkg.sv =====
// ----------------------------------------------------------------------------
// srtw_pkg: shared types and constants of the spherical ring weight block
// Holds fixed-point widths, register indexes and the cell payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package srtw_pkg;

   // Fraction bits of coordinates, offsets and inverse scales.
   localparam int COORD_FRAC_BITS = 16;

   // Ring width after alignment to the coordinate fraction bits.
   localparam int RING_W = COORD_FRAC_BITS + 8;
   // Width of a divisor: wide enough for twice the sum of both ring widths.
   localparam int DVS_W = RING_W + 2;
   // Width of 2*dist + r1, the dividend of the ring reduction.
   localparam int T_W = ((RING_W > 33) ? RING_W : 33) + 1;
   // Quotient bits of the band position and of the ramp.
   localparam int UQ_W = 16;
   // One cell of the square root per result bit.
   localparam int ROOT_CELLS = 32;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_OFFSET_X    = 3'd0,
      REG_OFFSET_Y    = 3'd1,
      REG_OFFSET_Z    = 3'd2,
      REG_INV_SCALE_X = 3'd3,
      REG_INV_SCALE_Y = 3'd4,
      REG_INV_SCALE_Z = 3'd5,
      REG_RING_WIDTHS = 3'd6,
      REG_BLUR_WIDTH  = 3'd7
   } reg_index_type;

   // Payload of one square root cell.
   typedef struct packed {
      logic        valid;
      logic [63:0] rad;
      logic [34:0] rem;
      logic [31:0] root;
   } root_type;

   // Payload of one restoring division cell.
   typedef struct packed {
      logic             valid;
      logic             band;
      logic             flag;
      logic [DVS_W-1:0] rem;
      logic [DVS_W-1:0] dvs;
      logic [T_W-1:0]   num;
      logic [UQ_W-1:0]  quo;
   } div_type;

endpackage

`default_nettype wire

// ===== rtl/core/srtw_axis.sv =====
// ----------------------------------------------------------------------------
// srtw_axis: offset, scale and square of one coordinate axis
// Four register stages: magnitudes, split partial products, saturated
// scaled magnitude, and its square.
// ----------------------------------------------------------------------------
`default_nettype none

module srtw_axis
   import srtw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] coord,
   input  wire logic [31:0] offset,
   input  wire logic [31:0] inv_scale,
   output logic      [61:0] sq
);

   logic [32:0] diff;
   logic [32:0] mag_in, mag_ff;
   logic [31:0] im_in, im_ff;
   logic [47:0] pl_ff;
   logic [48:0] ph_ff;
   logic [64:0] prod, shifted;
   logic [30:0] p_in, p_ff;
   logic [61:0] sq_ff;

   // Exact difference and magnitudes.
   always_comb begin
      diff   = {coord[31], coord} - {offset[31], offset};
      mag_in = diff[32] ? (~diff + 33'd1) : diff;
      im_in  = inv_scale[31] ? (~inv_scale + 32'd1) : inv_scale;
   end

   // Product split into two partial products, then rescaled and saturated.
   always_comb begin
      prod    = {ph_ff, 16'd0} + {17'd0, pl_ff};
      shifted = prod >> COORD_FRAC_BITS;
      p_in    = (shifted > 65'h7FFFFFFF) ? 31'h7FFFFFFF : shifted[30:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         im_ff  <= im_in;
         pl_ff  <= mag_ff[15:0] * im_ff;
         ph_ff  <= mag_ff[32:16] * im_ff;
         p_ff   <= p_in;
         sq_ff  <= p_ff * p_ff;
      end
   end

   assign sq = sq_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srtw_root_cell.sv =====
// ----------------------------------------------------------------------------
// srtw_root_cell: one bit of the integer square root
// Takes two radicand bits, tries the next root bit and hands on the result.
// ----------------------------------------------------------------------------
`default_nettype none

module srtw_root_cell
   import srtw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     en,
   input  wire root_type src,
   output root_type      dst
);

   root_type    cell_in, cell_ff;
   logic [34:0] rem_t, trial;
   logic        ge;

   // Restoring step: subtract 4*root+1 when it fits.
   always_comb begin
      rem_t         = {src.rem[32:0], src.rad[63:62]};
      trial         = {1'b0, src.root, 2'b01};
      ge            = rem_t >= trial;
      cell_in.valid = src.valid;
      cell_in.rad   = {src.rad[61:0], 2'b00};
      cell_in.rem   = ge ? (rem_t - trial) : rem_t;
      cell_in.root  = {src.root[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/core/srtw_div_cell.sv =====
// ----------------------------------------------------------------------------
// srtw_div_cell: one quotient bit of a restoring division
// Shifts in one dividend bit, subtracts the divisor when it fits and
// passes the band and flag bits along unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module srtw_div_cell
   import srtw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    en,
   input  wire div_type src,
   output div_type      dst
);

   div_type        cell_in, cell_ff;
   logic [DVS_W:0] rem_t, diff;
   logic           ge;

   always_comb begin
      rem_t   = {src.rem, src.num[T_W-1]};
      diff    = rem_t - {1'b0, src.dvs};
      ge      = rem_t >= {1'b0, src.dvs};
      cell_in = src;
      cell_in.rem = ge ? diff[DVS_W-1:0] : rem_t[DVS_W-1:0];
      cell_in.num = {src.num[T_W-2:0], 1'b0};
      cell_in.quo = {src.quo[UQ_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dst = cell_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spherical_ring_texture_weight.sv =====
// ----------------------------------------------------------------------------
// spherical_ring_texture_weight: concentric spherical ring blend weight
// Maps a 3-D point to the weight of the first of two alternating shells.
// ----------------------------------------------------------------------------
// Usage:
// A point enters on the req_ channel (coord_x/y/z, signed Q16.16) when
// req_valid is high and req_stall is low. The Q1.16 weight leaves on the
// rsp_ channel under the same valid/stall rule, one result per point, in
// order. One point is taken every cycle while req_stall is low. The stages
// are five front stages (offset, split multiply, saturation, square, sum),
// one cell per root bit of the 32-bit square root, one cell per dividend
// bit of the ring reduction, three setup stages, two 16-cell dividers for
// the band position and the ramp, and the output register.
// The csr_ port writes one register per cycle; write it only while no
// transaction is in flight. Reset restores the register defaults and
// empties the pipeline. When the receiver stalls, the result waits in the
// output register and the pipeline keeps going until one more result sits
// in a skid register; only then req_stall rises and every cell holds.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_ring_texture_weight
   import srtw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_coord_x,
   input  wire logic [31:0] req_coord_y,
   input  wire logic [31:0] req_coord_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [16:0] rsp_weight
);

   logic [31:0] off_ff [3];
   logic [31:0] inv_ff [3];
   logic [31:0] ring_ff;
   logic [15:0] blur_ff;

   logic        en;
   logic [4:0]  fv_ff;
   logic [61:0] sq [3];
   logic [63:0] sum_ff;

   root_type    root_s [ROOT_CELLS+1];
   div_type     mod_s  [T_W+1];
   div_type     u_s    [UQ_W+1];
   div_type     q_s    [UQ_W+1];
   div_type     modi_in, ui_in, qi_in;

   logic [RING_W-1:0] r1, r2;
   logic [DVS_W-1:0]  r1x2, r2x2, msum, tm;
   logic [T_W-1:0]    tsum;
   logic              first;
   logic [UQ_W-1:0]   u, uf;
   logic [16:0]       pd;
   logic              pv;

   logic        out_v_ff, skid_v_ff;
   logic [16:0] out_w_ff, skid_w_ff;
   logic        take;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            off_ff[i] <= 32'd0;
            inv_ff[i] <= 32'd65536;
         end
         ring_ff <= 32'h01000100;
         blur_ff <= 16'd6554;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_OFFSET_X:    off_ff[0] <= csr_wdata;
            REG_OFFSET_Y:    off_ff[1] <= csr_wdata;
            REG_OFFSET_Z:    off_ff[2] <= csr_wdata;
            REG_INV_SCALE_X: inv_ff[0] <= csr_wdata;
            REG_INV_SCALE_Y: inv_ff[1] <= csr_wdata;
            REG_INV_SCALE_Z: inv_ff[2] <= csr_wdata;
            REG_RING_WIDTHS: ring_ff   <= csr_wdata;
            REG_BLUR_WIDTH:  blur_ff   <= csr_wdata[15:0];
         endcase
      end
   end

   // The whole pipeline advances unless the skid register is occupied.
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // Front end: three axes and the sum of squares.
   srtw_axis u_axis_x (.clock(clock), .en(en), .coord(req_coord_x),
                       .offset(off_ff[0]), .inv_scale(inv_ff[0]), .sq(sq[0]));
   srtw_axis u_axis_y (.clock(clock), .en(en), .coord(req_coord_y),
                       .offset(off_ff[1]), .inv_scale(inv_ff[1]), .sq(sq[1]));
   srtw_axis u_axis_z (.clock(clock), .en(en), .coord(req_coord_z),
                       .offset(off_ff[2]), .inv_scale(inv_ff[2]), .sq(sq[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 5'd0;
      end else if (en) begin
         fv_ff <= {fv_ff[3:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
      end
   end

   // Square root chain.
   always_comb begin
      root_s[0].valid = fv_ff[4];
      root_s[0].rad   = sum_ff;
      root_s[0].rem   = 35'd0;
      root_s[0].root  = 32'd0;
   end

   for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_root
      srtw_root_cell u_cell (.clock(clock), .reset(reset), .en(en),
                             .src(root_s[k]), .dst(root_s[k+1]));
   end

   // Ring widths aligned to the coordinate fraction bits.
   always_comb begin
      r1   = RING_W'(ring_ff[15:0]) << (COORD_FRAC_BITS - 8);
      r2   = RING_W'(ring_ff[31:16]) << (COORD_FRAC_BITS - 8);
      r1x2 = DVS_W'({r1, 1'b0});
      r2x2 = DVS_W'({r2, 1'b0});
      msum = DVS_W'({1'b0, r1} + {1'b0, r2}) << 1;
      tsum = T_W'({root_s[ROOT_CELLS].root, 1'b0}) + T_W'(r1);
   end

   // Setup of the ring reduction: remainder of 2*dist + r1 by 2*(r1+r2).
   always_comb begin
      modi_in.valid = root_s[ROOT_CELLS].valid;
      modi_in.band  = 1'b0;
      modi_in.flag  = (msum == '0);
      modi_in.rem   = '0;
      modi_in.dvs   = msum;
      modi_in.num   = tsum;
      modi_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_s[0].valid <= 1'b0;
      end else if (en) begin
         mod_s[0] <= modi_in;
      end
   end

   for (genvar k = 0; k < T_W; k++) begin : g_mod
      srtw_div_cell u_cell (.clock(clock), .reset(reset), .en(en),
                            .src(mod_s[k]), .dst(mod_s[k+1]));
   end

   // Band selection and setup of the band position division.
   always_comb begin
      tm          = mod_s[T_W].flag ? '0 : mod_s[T_W].rem;
      first       = tm < r1x2;
      ui_in.valid = mod_s[T_W].valid;
      ui_in.band  = first;
      ui_in.flag  = !first && (r2 == '0);
      ui_in.rem   = first ? tm : (tm - r1x2);
      ui_in.dvs   = first ? r1x2 : r2x2;
      ui_in.num   = '0;
      ui_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_s[0].valid <= 1'b0;
      end else if (en) begin
         u_s[0] <= ui_in;
      end
   end

   for (genvar k = 0; k < UQ_W; k++) begin : g_u
      srtw_div_cell u_cell (.clock(clock), .reset(reset), .en(en),
                            .src(u_s[k]), .dst(u_s[k+1]));
   end

   // Fold about the band middle and decide between flat and ramp.
   always_comb begin
      u           = u_s[UQ_W].flag ? '0 : u_s[UQ_W].quo;
      uf          = (u > 16'd32768) ? 16'(17'd65536 - {1'b0, u}) : u;
      qi_in.valid = u_s[UQ_W].valid;
      qi_in.band  = u_s[UQ_W].band;
      qi_in.flag  = ({uf, 1'b0} >= {1'b0, blur_ff});
      qi_in.rem   = DVS_W'(uf);
      qi_in.dvs   = DVS_W'(blur_ff);
      qi_in.num   = '0;
      qi_in.quo   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_s[0].valid <= 1'b0;
      end else if (en) begin
         q_s[0] <= qi_in;
      end
   end

   for (genvar k = 0; k < UQ_W; k++) begin : g_q
      srtw_div_cell u_cell (.clock(clock), .reset(reset), .en(en),
                            .src(q_s[k]), .dst(q_s[k+1]));
   end

   // Final weight of the transaction leaving the pipeline.
   always_comb begin
      pv = q_s[UQ_W].valid;
      priority if (q_s[UQ_W].flag) begin
         pd = q_s[UQ_W].band ? 17'd65536 : 17'd0;
      end else if (q_s[UQ_W].band) begin
         pd = 17'd32768 + 17'(q_s[UQ_W].quo);
      end else begin
         pd = 17'd32768 - 17'(q_s[UQ_W].quo);
      end
   end

   // Output register with a skid register behind it.
   assign take = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            out_w_ff  <= skid_w_ff;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= pv;
            out_w_ff <= pd;
         end
      end else if (en && pv) begin
         skid_v_ff <= 1'b1;
         skid_w_ff <= pd;
      end
   end

   assign rsp_valid  = out_v_ff;
   assign rsp_weight = out_w_ff;

endmodule

`default_nettype wire

// ===== bench/spherical_ring_texture_weight_check.sv =====
// ----------------------------------------------------------------------------
// spherical_ring_texture_weight_check: result checker of the ring weight block
// Watches the register port and both channels. For every point the block
// accepts, it works out the expected weight from its own copy of the
// registers. It then compares each weight the block delivers, in order,
// with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spherical_ring_texture_weight_check
   import srtw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [31:0] req_coord_z,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [16:0] rsp_weight,
   output int          mismatches,
   output int          pending,
   output int          weights_checked
);

   // Shadow copy of the block's registers.
   logic [31:0] origin[3];
   logic [31:0] inv_scale[3];
   logic [31:0] ring_widths;
   logic [15:0] blur_width;

   logic [16:0] weights_due[$];

   // Integer square root, rounded down.
   function automatic logic [63:0] floor_sqrt(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // Weight of the first surface at one point, under the current registers.
   function automatic logic [16:0] ring_weight(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz);
      logic [31:0]        coord[3];
      logic signed [63:0] delta;
      logic signed [63:0] scale;
      logic [63:0]        prod, sumsq, radius, r1, r2, phase, period, u, w;
      logic               in_first;
      coord[0] = cx;
      coord[1] = cy;
      coord[2] = cz;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
         delta = {{32{coord[i][31]}}, coord[i]} - {{32{origin[i][31]}}, origin[i]};
         scale = {{32{inv_scale[i][31]}}, inv_scale[i]};
         if (delta < 0) delta = -delta;
         if (scale < 0) scale = -scale;
         prod = (64'(delta) * 64'(scale)) >> COORD_FRAC_BITS;
         if (prod > 64'h7FFF_FFFF) prod = 64'h7FFF_FFFF;
         sumsq = sumsq + prod * prod;
      end
      radius = floor_sqrt(sumsq);

      // Ring widths are Q8.8; align them to the coordinate fraction bits.
      r1 = 64'(ring_widths[15:0]) << (COORD_FRAC_BITS - 8);
      r2 = 64'(ring_widths[31:16]) << (COORD_FRAC_BITS - 8);
      phase = 2 * radius + r1;
      period = 2 * (r1 + r2);
      phase = (period != 0) ? phase % period : 0;

      // Position within the band, then folded about its middle.
      if (phase < 2 * r1) begin
         in_first = 1'b1;
         u = (phase << 16) / (2 * r1);
      end else begin
         in_first = 1'b0;
         phase = phase - 2 * r1;
         u = (r2 != 0) ? (phase << 16) / (2 * r2) : 0;
      end
      if (u > 32768) u = 65536 - u;

      // Flat inside the band, linear ramp through one half near an edge.
      if (2 * u >= 64'(blur_width))
         w = in_first ? 65536 : 0;
      else
         w = in_first ? 32768 + (u << 16) / blur_width
                      : 32768 - (u << 16) / blur_width;
      if (w > 65536) w = 65536;
      return w[16:0];
   endfunction

   // Track register writes and predict each accepted transaction.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            origin[i] <= 32'd0;
            inv_scale[i] <= 32'd65536;
         end
         ring_widths <= 32'h0100_0100;
         blur_width <= 16'd6554;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_OFFSET_X:    origin[0] <= csr_wdata;
               REG_OFFSET_Y:    origin[1] <= csr_wdata;
               REG_OFFSET_Z:    origin[2] <= csr_wdata;
               REG_INV_SCALE_X: inv_scale[0] <= csr_wdata;
               REG_INV_SCALE_Y: inv_scale[1] <= csr_wdata;
               REG_INV_SCALE_Z: inv_scale[2] <= csr_wdata;
               REG_RING_WIDTHS: ring_widths <= csr_wdata;
               REG_BLUR_WIDTH:  blur_width <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            weights_due.push_back(ring_weight(req_coord_x, req_coord_y, req_coord_z));
      end
   end

   // Compare each delivered weight with the oldest prediction.
   initial begin
      mismatches = 0;
      weights_checked = 0;
   end

   always @(posedge clock) begin
      logic [16:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (weights_due.size() == 0) begin
            $error("weight: unexpected transaction, actual %0d", rsp_weight);
            mismatches++;
         end else begin
            want = weights_due.pop_front();
            weights_checked++;
            if (rsp_weight !== want) begin
               $error("weight: expected %0d, actual %0d", want, rsp_weight);
               mismatches++;
            end
         end
      end
   end

   always_comb pending = weights_due.size();

endmodule

// ===== bench/spherical_ring_texture_weight_test.sv =====
// ----------------------------------------------------------------------------
// spherical_ring_texture_weight_test: top of the ring weight testbench
// Drives points through a series of register settings (defaults, dropped
// and extreme axes, empty ring bands, zero and full blur), first directed
// and then random, with random idle bursts on both channels. The checker
// beside the block predicts and compares every weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spherical_ring_texture_weight_test;
   import srtw_pkg::*;

   localparam int PHASES = 10;
   localparam int POINTS_PER_PHASE = 70;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_OFFSET_X;
   logic [31:0] csr_wdata = 32'd0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_coord_x = 32'd0;
   logic [31:0] req_coord_y = 32'd0;
   logic [31:0] req_coord_z = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [16:0] rsp_weight;

   int mismatches, pending, weights_checked;
   int points_sent = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   bit idling_on = 1'b0;
   bit quiet = 1'b0;
   logic [31:0] aim[3];

   always #1 clock = ~clock;

   spherical_ring_texture_weight DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_weight(rsp_weight)
   );

   spherical_ring_texture_weight_check checker_inst (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_weight(rsp_weight),
      .mismatches(mismatches), .pending(pending), .weights_checked(weights_checked)
   );

   // Receiver stalls in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && idling_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // End the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // Write every register, then release the write port.
   task automatic load_settings(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                logic [31:0] rings, logic [15:0] blur);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_OFFSET_Z, oz);
      write_reg(REG_INV_SCALE_X, sx);
      write_reg(REG_INV_SCALE_Y, sy);
      write_reg(REG_INV_SCALE_Z, sz);
      write_reg(REG_RING_WIDTHS, rings);
      write_reg(REG_BLUR_WIDTH, {16'd0, blur});
      @(negedge clock);
      csr_we <= 1'b0;
      aim[0] = ox;
      aim[1] = oy;
      aim[2] = oz;
   endtask

   // Send one point, possibly after a sender gap, and wait for acceptance.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      if (!quiet && idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      points_sent++;
   endtask

   // Let the pipeline drain before touching the registers.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly points near the pattern origin, where the rings are resolved.
   function automatic logic [31:0] pick_coord(int axis);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1, 2: return aim[axis] + 32'($urandom_range(0, 12 << 16)) - 32'(6 << 16);
         default: return 32'($urandom_range(0, 8 << 16)) - 32'(4 << 16);
      endcase
   endfunction

   initial begin
      logic [31:0] rings;
      aim[0] = 0;
      aim[1] = 0;
      aim[2] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed points under the reset defaults: unit rings, blur 0.1.
      send_point(32'd0, 32'd0, 32'd0);
      send_point(32'h0000_8000, 32'd0, 32'd0);
      send_point(32'h0001_0000, 32'd0, 32'd0);
      send_point(32'h0000_C000, 32'd0, 32'd0);
      send_point(32'h0000_7300, 32'd0, 32'd0);
      send_point(32'h0000_8D00, 32'd0, 32'd0);
      send_point(32'h0001_8000, 32'h0000_0001, 32'd0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'hFFFF_0000, 32'hFFFF_8000, 32'h0000_4000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      send_point(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
      send_point(32'h0002_4000, 32'hFFFD_C000, 32'h0001_0000);
      drain();

      for (int phase = 1; phase < PHASES; phase++) begin
         idling_on = (phase % 3) != 2;
         quiet = (phase == PHASES - 1);
         rings = {16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024))};
         case (phase)
            1: load_settings($urandom, $urandom, $urandom, 32'd65536, 32'd65536,
                             32'd65536, 32'h0100_0100, 16'hFFFF);
            2: load_settings($urandom, $urandom, $urandom, 32'd0, 32'hFFFF_0000,
                             32'h7FFF_FFFF, rings, 16'd0);
            3: load_settings(32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0,
                             32'h0200_0000, 16'd9000);
            4: load_settings(32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd0,
                             32'h0000_0300, 16'd3000);
            5: load_settings($urandom, 32'd0, 32'd0, 32'd65536, 32'd65536, 32'd65536,
                             32'd0, 16'($urandom));
            6: load_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'hFFFF_FFFF, 16'hFFFF);
            7: load_settings($urandom, $urandom, $urandom,
                             32'($urandom_range(1, 1 << 18)), $urandom,
                             32'($urandom_range(1, 1 << 17)), rings, 16'd1);
            default: load_settings($urandom, $urandom, $urandom,
                                   32'($urandom_range(1 << 14, 1 << 18)),
                                   32'($urandom_range(1 << 14, 1 << 18)),
                                   32'($urandom_range(1 << 14, 1 << 18)),
                                   rings, 16'($urandom_range(0, 40000)));
         endcase
         for (int n = 0; n < POINTS_PER_PHASE; n++)
            send_point(pick_coord(0), pick_coord(1), pick_coord(2));
         drain();
      end

      repeat (120) @(posedge clock);
      $display("Sent %0d points over %0d register settings; %0d weights checked.",
               points_sent, PHASES, weights_checked);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== spherical_ring_texture_weight.f =====
rtl/core/srtw_pkg.sv
rtl/core/srtw_axis.sv
rtl/core/srtw_root_cell.sv
rtl/core/srtw_div_cell.sv
rtl/core/spherical_ring_texture_weight.sv
bench/spherical_ring_texture_weight_check.sv
bench/spherical_ring_texture_weight_test.sv
